// File: hdl/gte_pkg.sv
// gte_pkg: shared types and codes of the graph traversal engine.
// Holds operation, status and register codes and the fixed field widths.
// No dependencies.
`default_nettype none

package gte_pkg;

	localparam int VERTEX_W = 6;
	localparam int NV_W     = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_WALK_ONE = 2'd1,
		OP_WALK_ALL = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef logic [VERTEX_W-1:0] vertex_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_VERTEX    = 2'd0;
	localparam status_t ST_STORED    = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_BAD_VERTEX = 2'd3;

	// register word index (paddr[2])
	localparam logic REG_NUM_VERTICES = 1'b0;
	localparam logic REG_DIRECTED     = 1'b1;

	localparam logic WALK_DFS = 1'b0;

endpackage

`default_nettype wire

// File: hdl/graph_traversal_engine_top.sv
// graph_traversal_engine_top: edge-list graph store with DFS/BFS traversal.
// Edge store and pending stack/queue are synchronous memories in this module.
// Depends on gte_pkg.
//
// Usage:
//   Input words arrive on s_axis: tuser carries the operation and walk order,
//   tdata the source and destination vertex. Results leave on m_axis: tdata
//   carries the vertex, tuser the status, tlast marks the final result of an
//   input word. Registers num_vertices and directed sit on the APB port at
//   byte addresses 0 and 4; the user must write them only while the block is
//   idle, as the block itself does not enforce this. An add-edge word gives
//   one result, loaded into the output register from the response state.
//   A traversal pops one vertex at a time; each pop reads the pending memory
//   and then scans the edge store once, one edge per cycle, and each component
//   closes with one empty pop. A traverse-all word also sweeps every vertex
//   and makes one final sweep step past the last. The scan rate is set by the
//   single read port of the edge store.
//   One item is worked on at a time; s_axis_tready is high only between items.
//   Each result is held back one pop so that tlast can be set on the final one.
//   When the receiver stalls, the output register holds its word and the
//   traversal waits at the next emission.
//   Reset clears the edge count, the visited map, the pending pointers and the
//   output register; registers return to 64 vertices, undirected.
`default_nettype none

module graph_traversal_engine_top #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // [5:0] src_vertex, [11:6] dst_vertex, [15:12] zero
	input  wire  [2:0]  s_axis_tuser,  // [1:0] operation, [2] walk_order
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [5:0] vertex, [7:6] zero
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser,  // [1:0] status
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int VW  = gte_pkg::VERTEX_W;
	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int PW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_POP_REQ,
		S_POP_WAIT,
		S_SCAN,
		S_COMP,
		S_END
	} state_t;

	state_t state_q;

	// configuration
	logic [gte_pkg::NV_W-1:0] num_vertices_q;
	logic                     directed_q;
	logic [gte_pkg::NV_W-1:0] nv;

	// item
	gte_pkg::op_t    op_q;
	logic            walk_q;
	gte_pkg::status_t resp_status_q;

	// traversal
	logic [MAX_VERTICES-1:0]   visited_q;
	logic [PW-1:0]             head_q;
	logic [PW-1:0]             tail_q;
	logic [gte_pkg::NV_W-1:0]  comp_i_q;
	gte_pkg::vertex_t          cur_v_q;
	logic                      hold_valid_q;
	gte_pkg::vertex_t          hold_vertex_q;
	logic [ECW-1:0]            edge_count_q;
	logic [ECW-1:0]            eidx_q;

	// output register
	logic             out_valid_q;
	gte_pkg::vertex_t out_vertex_q;
	logic             out_last_q;
	gte_pkg::status_t out_status_q;

	// memories
	logic [2*VW-1:0] edge_mem [MAX_EDGES];
	logic [2*VW-1:0] edge_rdata_q;
	logic [VW-1:0]   pend_mem [MAX_VERTICES];
	logic [VW-1:0]   pend_rdata_q;

	logic             in_accept;
	gte_pkg::op_t     in_op;
	logic             in_walk;
	gte_pkg::vertex_t in_src;
	gte_pkg::vertex_t in_dst;
	logic             src_ok;
	logic             dst_ok;
	logic             edge_full;
	logic             out_free;
	logic             out_load;
	logic             edge_we;
	logic             edge_re;
	logic [EAW-1:0]   edge_raddr;
	logic             pend_re;
	logic [VAW-1:0]   pend_raddr;
	logic             pending_nonempty;
	logic             pop_go;
	gte_pkg::vertex_t edge_a;
	gte_pkg::vertex_t edge_b;
	logic             push_fwd;
	logic             push_rev;
	logic             comp_in_range;
	logic             comp_unvisited;
	logic             push_en;
	gte_pkg::vertex_t push_v;
	logic             scan_more;

	function automatic logic below_nv(input gte_pkg::vertex_t v,
		input logic [gte_pkg::NV_W-1:0] n);
		below_nv = ({1'b0, v} < n);
	endfunction

	// clamp the vertex count to 1..MAX_VERTICES
	always_comb begin
		if (num_vertices_q == '0) begin
			nv = gte_pkg::NV_W'(1);
		end else if (num_vertices_q > gte_pkg::NV_W'(MAX_VERTICES)) begin
			nv = gte_pkg::NV_W'(MAX_VERTICES);
		end else begin
			nv = num_vertices_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign in_op         = gte_pkg::op_t'(s_axis_tuser[1:0]);
	assign in_walk       = s_axis_tuser[2];
	assign in_src        = s_axis_tdata[VW-1:0];
	assign in_dst        = s_axis_tdata[2*VW-1:VW];
	assign src_ok        = below_nv(in_src, nv);
	assign dst_ok        = below_nv(in_dst, nv);
	assign edge_full     = (edge_count_q == ECW'(MAX_EDGES));
	assign out_free      = !out_valid_q || m_axis_tready;

	assign edge_we = in_accept && (in_op == gte_pkg::OP_ADD_EDGE) && src_ok && dst_ok
		&& !edge_full;

	assign pending_nonempty = (walk_q == gte_pkg::WALK_DFS) ? (tail_q != '0)
		: (head_q != tail_q);
	assign pend_re           = (state_q == S_POP_REQ) && pending_nonempty;
	assign pend_raddr        = (walk_q == gte_pkg::WALK_DFS) ? VAW'(tail_q - PW'(1))
		: head_q[VAW-1:0];

	assign pop_go    = (state_q == S_POP_WAIT) && (!hold_valid_q || out_free);
	assign scan_more = (eidx_q < edge_count_q);
	assign edge_re   = (pop_go && (edge_count_q != '0)) || ((state_q == S_SCAN) && scan_more);
	assign edge_raddr = (state_q == S_POP_WAIT) ? '0 : eidx_q[EAW-1:0];

	// output register loads a new word this cycle
	assign out_load = out_free && ((state_q == S_RESP) || (state_q == S_END)
		|| ((state_q == S_POP_WAIT) && hold_valid_q));

	assign edge_a = edge_rdata_q[2*VW-1:VW];
	assign edge_b = edge_rdata_q[VW-1:0];

	// an edge pushes at most one neighbor: both matches only on a self loop of v
	assign push_fwd = (edge_a == cur_v_q) && below_nv(edge_b, nv)
		&& !visited_q[edge_b[VAW-1:0]];
	assign push_rev = !directed_q && (edge_b == cur_v_q) && below_nv(edge_a, nv)
		&& !visited_q[edge_a[VAW-1:0]];

	assign comp_in_range  = (comp_i_q < nv);
	assign comp_unvisited = !visited_q[comp_i_q[VAW-1:0]];

	always_comb begin
		push_en = 1'b0;
		push_v  = edge_b;
		unique case (state_q)
			S_IDLE: begin
				push_en = in_accept && (in_op == gte_pkg::OP_WALK_ONE) && src_ok;
				push_v  = in_src;
			end
			S_SCAN: begin
				push_en = push_fwd || push_rev;
				push_v  = push_fwd ? edge_b : edge_a;
			end
			S_COMP: begin
				push_en = comp_in_range && comp_unvisited;
				push_v  = comp_i_q[VW-1:0];
			end
			default: begin
				push_en = 1'b0;
				push_v  = edge_b;
			end
		endcase
	end

	// edge store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_count_q[EAW-1:0]] <= {in_src, in_dst};
		end
		if (edge_re) begin
			edge_rdata_q <= edge_mem[edge_raddr];
		end
	end

	// pending stack / queue
	always_ff @(posedge clk) begin
		if (push_en) begin
			pend_mem[tail_q[VAW-1:0]] <= push_v;
		end
		if (pend_re) begin
			pend_rdata_q <= pend_mem[pend_raddr];
		end
	end

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			gte_pkg::REG_NUM_VERTICES: prdata = {25'd0, num_vertices_q};
			gte_pkg::REG_DIRECTED:     prdata = {31'd0, directed_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= gte_pkg::NV_W'(64);
			directed_q     <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				gte_pkg::REG_NUM_VERTICES: num_vertices_q <= pwdata[gte_pkg::NV_W-1:0];
				gte_pkg::REG_DIRECTED:     directed_q     <= pwdata[0];
				default:                   directed_q     <= directed_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= gte_pkg::OP_NONE;
			walk_q        <= gte_pkg::WALK_DFS;
			resp_status_q <= gte_pkg::ST_STORED;
			visited_q     <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			comp_i_q      <= '0;
			cur_v_q       <= '0;
			hold_valid_q  <= 1'b0;
			hold_vertex_q <= '0;
			edge_count_q  <= '0;
			eidx_q        <= '0;
			out_valid_q   <= 1'b0;
			out_vertex_q  <= '0;
			out_last_q    <= 1'b0;
			out_status_q  <= gte_pkg::ST_VERTEX;
		end else begin
			if (m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						op_q   <= in_op;
						walk_q <= in_walk;
						unique case (in_op)
							gte_pkg::OP_ADD_EDGE: begin
								if (!src_ok || !dst_ok) begin
									resp_status_q <= gte_pkg::ST_BAD_VERTEX;
								end else if (edge_full) begin
									resp_status_q <= gte_pkg::ST_FULL;
								end else begin
									resp_status_q <= gte_pkg::ST_STORED;
									edge_count_q  <= edge_count_q + ECW'(1);
								end
								state_q <= S_RESP;
							end
							gte_pkg::OP_WALK_ONE: begin
								if (!src_ok) begin
									resp_status_q <= gte_pkg::ST_BAD_VERTEX;
									state_q       <= S_RESP;
								end else begin
									// fresh map with the start vertex marked
									visited_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1}
										<< in_src[VAW-1:0];
									head_q    <= '0;
									state_q   <= S_POP_REQ;
								end
							end
							gte_pkg::OP_WALK_ALL: begin
								visited_q <= '0;
								comp_i_q  <= '0;
								state_q   <= S_COMP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_vertex_q <= '0;
						out_last_q   <= 1'b1;
						out_status_q <= resp_status_q;
						state_q      <= S_IDLE;
					end
				end
				S_POP_REQ: begin
					if (pending_nonempty) begin
						if (walk_q == gte_pkg::WALK_DFS) begin
							tail_q <= tail_q - PW'(1);
						end else begin
							head_q <= head_q + PW'(1);
						end
						state_q <= S_POP_WAIT;
					end else begin
						// component done: rewind the pending pointers
						head_q  <= '0;
						tail_q  <= '0;
						state_q <= (op_q == gte_pkg::OP_WALK_ALL) ? S_COMP : S_END;
					end
				end
				S_POP_WAIT: begin
					if (pop_go) begin
						if (hold_valid_q) begin
							out_valid_q  <= 1'b1;
							out_vertex_q <= hold_vertex_q;
							out_last_q   <= 1'b0;
							out_status_q <= gte_pkg::ST_VERTEX;
						end
						hold_valid_q  <= 1'b1;
						hold_vertex_q <= pend_rdata_q;
						cur_v_q       <= pend_rdata_q;
						eidx_q        <= ECW'(1);
						state_q       <= (edge_count_q != '0) ? S_SCAN : S_POP_REQ;
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						eidx_q <= eidx_q + ECW'(1);
					end else begin
						state_q <= S_POP_REQ;
					end
				end
				S_COMP: begin
					comp_i_q <= comp_i_q + gte_pkg::NV_W'(1);
					if (!comp_in_range) begin
						state_q <= S_END;
					end else if (comp_unvisited) begin
						head_q  <= '0;
						state_q <= S_POP_REQ;
					end
				end
				S_END: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_vertex_q <= hold_vertex_q;
						out_last_q   <= 1'b1;
						out_status_q <= gte_pkg::ST_VERTEX;
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// mark on push; a single walk marks its start vertex at acceptance
			if (push_en) begin
				if (state_q != S_IDLE) begin
					visited_q[push_v[VAW-1:0]] <= 1'b1;
				end
				tail_q <= tail_q + PW'(1);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8 - VW){1'b0}}, out_vertex_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

`ifndef NO_ASSERTIONS
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= PW'(MAX_VERTICES))
		else $error("pending tail beyond depth");

	a_push_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && (state_q != S_IDLE)) |-> !visited_q[push_v[VAW-1:0]])
		else $error("push of a visited vertex");

	a_edge_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		edge_we |-> (edge_count_q < ECW'(MAX_EDGES)))
		else $error("edge write into a full store");

	a_end_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END) |-> hold_valid_q)
		else $error("traversal ends with no vertex held");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((eidx_q <= edge_count_q) && (eidx_q != '0)))
		else $error("edge scan index out of range");
`endif

endmodule

`default_nettype wire

// File: dv/gte_traversal_checker.sv
// gte_traversal_checker: watches the input, result and register ports of the traversal engine.
// Keeps its own graph, visited map and pending list, predicts every result word and compares.
// Depends on gte_pkg.
`timescale 1ns / 100ps

module gte_traversal_checker #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // [5:0] src_vertex, [11:6] dst_vertex, [15:12] zero
	input  wire  [2:0]  s_axis_tuser,  // [1:0] operation, [2] walk_order
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [7:0]  m_axis_tdata,  // [5:0] vertex, [7:6] zero
	input  wire         m_axis_tlast,
	input  wire  [1:0]  m_axis_tuser,  // [1:0] status
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	output int          fail_count,
	output int          outstanding,
	output int          words_checked,
	output int          full_hits,
	output int          bad_hits
);

	localparam int REPORT_CAP = 40;

	typedef struct packed {
		gte_pkg::vertex_t vertex;
		logic             last;
		gte_pkg::status_t status;
	} result_t;

	result_t          predicted_results[$];
	result_t          visit_order[$];
	result_t          got_word;
	result_t          exp_word;

	gte_pkg::vertex_t edge_from [MAX_EDGES];
	gte_pkg::vertex_t edge_to   [MAX_EDGES];
	int unsigned      edge_total;
	bit               visited   [MAX_VERTICES];
	gte_pkg::vertex_t pending   [MAX_VERTICES];
	int unsigned      pend_head;
	int unsigned      pend_tail;
	logic [gte_pkg::NV_W-1:0] num_vertices_reg;
	logic             directed_reg;

	function automatic result_t make_result(gte_pkg::vertex_t v, logic last,
		gte_pkg::status_t st);
		result_t r;
		r.vertex = v;
		r.last   = last;
		r.status = st;
		return r;
	endfunction

	function automatic void expect_word(result_t r);
		predicted_results = {predicted_results, r};
	endfunction

	function automatic void record_visit(result_t r);
		visit_order = {visit_order, r};
	endfunction

	function automatic int unsigned vertex_span();
		if (num_vertices_reg == 0)
			return 1;
		if (num_vertices_reg > MAX_VERTICES)
			return MAX_VERTICES;
		return 32'(num_vertices_reg);
	endfunction

	function automatic void clear_visited();
		foreach (visited[i])
			visited[i] = 1'b0;
	endfunction

	// mark on push, so a vertex enters the pending list at most once per walk
	function automatic void mark_pending(gte_pkg::vertex_t v, int unsigned span);
		if (v >= span || visited[v])
			return;
		if (pend_tail >= MAX_VERTICES)
			return;
		visited[v] = 1'b1;
		pending[pend_tail] = v;
		pend_tail++;
	endfunction

	function automatic void walk_from(gte_pkg::vertex_t start, bit breadth, int unsigned span);
		gte_pkg::vertex_t v;
		pend_head = 0;
		pend_tail = 0;
		mark_pending(start, span);
		while (pend_head < pend_tail) begin
			if (breadth) begin
				v = pending[pend_head];
				pend_head++;
			end else begin
				pend_tail--;
				v = pending[pend_tail];
			end
			if (visit_order.size() < MAX_VERTICES)
				record_visit(make_result(v, 1'b0, gte_pkg::ST_VERTEX));
			// neighbors come in edge insertion order, reverse direction at the same slot
			for (int unsigned e = 0; e < edge_total; e++) begin
				if (edge_from[e] == v)
					mark_pending(edge_to[e], span);
				if (!directed_reg && edge_to[e] == v)
					mark_pending(edge_from[e], span);
			end
		end
		pend_head = 0;
		pend_tail = 0;
	endfunction

	function automatic void predict_results(gte_pkg::op_t op, logic walk,
		gte_pkg::vertex_t src, gte_pkg::vertex_t dst);
		int unsigned span;
		span = vertex_span();
		visit_order.delete();
		case (op)
			gte_pkg::OP_ADD_EDGE: begin
				if (src >= span || dst >= span) begin
					expect_word(make_result('0, 1'b1, gte_pkg::ST_BAD_VERTEX));
				end else if (edge_total >= MAX_EDGES) begin
					expect_word(make_result('0, 1'b1, gte_pkg::ST_FULL));
				end else begin
					edge_from[edge_total] = src;
					edge_to[edge_total]   = dst;
					edge_total++;
					expect_word(make_result('0, 1'b1, gte_pkg::ST_STORED));
				end
			end
			gte_pkg::OP_WALK_ONE: begin
				if (src >= span) begin
					expect_word(make_result('0, 1'b1, gte_pkg::ST_BAD_VERTEX));
				end else begin
					clear_visited();
					walk_from(src, walk != gte_pkg::WALK_DFS, span);
				end
			end
			gte_pkg::OP_WALK_ALL: begin
				clear_visited();
				for (int unsigned i = 0; i < span; i++)
					if (!visited[i])
						walk_from(gte_pkg::vertex_t'(i), walk != gte_pkg::WALK_DFS, span);
			end
			default: ;
		endcase
		if (visit_order.size() != 0) begin
			visit_order[visit_order.size() - 1].last = 1'b1;
			foreach (visit_order[i])
				expect_word(visit_order[i]);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			predicted_results.delete();
			edge_total       = 0;
			num_vertices_reg = gte_pkg::NV_W'(MAX_VERTICES);
			directed_reg     = 1'b0;
			clear_visited();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == gte_pkg::REG_NUM_VERTICES)
					num_vertices_reg = pwdata[gte_pkg::NV_W-1:0];
				else
					directed_reg = pwdata[0];
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_results(gte_pkg::op_t'(s_axis_tuser[1:0]), s_axis_tuser[2],
					s_axis_tdata[5:0], s_axis_tdata[11:6]);
			if (m_axis_tvalid && m_axis_tready) begin
				got_word = make_result(m_axis_tdata[gte_pkg::VERTEX_W-1:0], m_axis_tlast,
					m_axis_tuser);
				if (predicted_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%0t: unexpected word v%0d l%0d s%0d, expected none",
							$time, got_word.vertex, got_word.last, got_word.status);
				end else begin
					exp_word = predicted_results.pop_front();
					words_checked++;
					if (exp_word.status == gte_pkg::ST_FULL)
						full_hits++;
					if (exp_word.status == gte_pkg::ST_BAD_VERTEX)
						bad_hits++;
					if (got_word.vertex !== exp_word.vertex || got_word.last !== exp_word.last
						|| got_word.status !== exp_word.status) begin
						fail_count++;
						if (fail_count <= REPORT_CAP)
							$display("%0t: expected v%0d l%0d s%0d, got v%0d l%0d s%0d",
								$time, exp_word.vertex, exp_word.last, exp_word.status,
								got_word.vertex, got_word.last, got_word.status);
					end
				end
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

// File: dv/testbench.sv
// testbench: drives the graph traversal engine with edges, traversals and register settings.
// Results are predicted and compared by gte_traversal_checker; this module gives the verdict.
// Depends on gte_pkg, graph_traversal_engine_top and gte_traversal_checker.
`timescale 1ns / 100ps

module testbench;

	localparam int   MAX_VERTICES  = 64;
	localparam int   MAX_EDGES     = 256;
	localparam logic WALK_BFS      = ~gte_pkg::WALK_DFS;
	localparam logic WALK_DFS      = gte_pkg::WALK_DFS;
	localparam int   SETTLE_CYCLES = 16;
	localparam int   TIMEOUT_NS    = 100_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [5:0] src_vertex, [11:6] dst_vertex, [15:12] zero
	logic [2:0]  s_axis_tuser = '0;  // [1:0] operation, [2] walk_order
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [7:0]  m_axis_tdata;       // [5:0] vertex, [7:6] zero
	wire         m_axis_tlast;
	wire  [1:0]  m_axis_tuser;       // [1:0] status
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	int          fail_count;
	int          outstanding;
	int          words_checked;
	int          full_hits;
	int          bad_hits;

	int unsigned span_now = MAX_VERTICES;
	int unsigned words_sent;
	int unsigned settings_used;
	int unsigned stall_left;
	int unsigned stall_draw;
	bit          tx_quiet;
	bit          rx_quiet;

	graph_traversal_engine_top #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_dut (.*);

	gte_traversal_checker #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: hold ready low for a drawn number of cycles after every word
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			stall_draw = rx_quiet ? 0 : $urandom_range(0, 7);
			stall_left    <= stall_draw;
			m_axis_tready <= (stall_draw == 0);
		end else if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_word(gte_pkg::op_t op, logic walk, gte_pkg::vertex_t src,
		gte_pkg::vertex_t dst);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {walk, op};
		s_axis_tdata  <= {4'b0000, dst, src};
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	// drain every predicted word, then let a word with no results finish too
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int unsigned nv, logic dir);
		wait_drained();
		write_reg(gte_pkg::REG_NUM_VERTICES, nv);
		write_reg(gte_pkg::REG_DIRECTED, {31'b0, dir});
		settings_used++;
		span_now = (nv == 0) ? 1 : (nv > MAX_VERTICES) ? MAX_VERTICES : nv;
		tx_quiet = ($urandom_range(0, 3) == 0);
		rx_quiet = ($urandom_range(0, 3) == 0);
	endtask

	// mostly in-range edges and walks; some out-of-range vertices and unused codes
	task automatic send_random_word();
		int unsigned      pick;
		gte_pkg::vertex_t a;
		gte_pkg::vertex_t b;
		logic             walk;
		pick = $urandom_range(0, 99);
		a    = gte_pkg::vertex_t'($urandom_range(0, span_now - 1));
		b    = gte_pkg::vertex_t'($urandom_range(0, span_now - 1));
		walk = 1'($urandom_range(0, 1));
		if (pick < 55)
			send_word(gte_pkg::OP_ADD_EDGE, walk, a, b);
		else if (pick < 65)
			send_word(gte_pkg::OP_ADD_EDGE, walk, gte_pkg::vertex_t'($urandom),
				gte_pkg::vertex_t'($urandom));
		else if (pick < 80)
			send_word(gte_pkg::OP_WALK_ONE, walk, a, gte_pkg::vertex_t'($urandom));
		else if (pick < 85)
			send_word(gte_pkg::OP_WALK_ONE, walk, gte_pkg::vertex_t'($urandom),
				gte_pkg::vertex_t'($urandom));
		else if (pick < 95)
			send_word(gte_pkg::OP_WALK_ALL, walk, gte_pkg::vertex_t'($urandom),
				gte_pkg::vertex_t'($urandom));
		else
			send_word(gte_pkg::OP_NONE, walk, gte_pkg::vertex_t'($urandom),
				gte_pkg::vertex_t'($urandom));
	endtask

	initial begin
		int unsigned nv;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		arst_n   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: 64 vertices, undirected
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd0, 6'd63);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_BFS, 6'd63, 6'd1);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd1, 6'd2);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd2, 6'd0);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_BFS, 6'd5, 6'd5);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd63, 6'd62);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd0, 6'd63);
		send_word(gte_pkg::OP_WALK_ONE, WALK_BFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ALL, WALK_DFS, 6'd63, 6'd63);
		send_word(gte_pkg::OP_WALK_ALL, WALK_BFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_NONE, WALK_BFS, 6'd63, 6'd63);
		send_word(gte_pkg::OP_WALK_ONE, WALK_BFS, 6'd63, 6'd21);

		// fewer vertices, directed: bad vertices and stale edges
		configure(8, 1'b1);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd9, 6'd1);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd1, 6'd40);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_BFS, 6'd3, 6'd4);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd4, 6'd1);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd9, 6'd0);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd3, 6'd0);
		send_word(gte_pkg::OP_WALK_ALL, WALK_BFS, 6'd0, 6'd0);

		// zero acts as one vertex
		configure(0, 1'b0);
		send_word(gte_pkg::OP_WALK_ALL, WALK_DFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ONE, WALK_BFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd1, 6'd0);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd0, 6'd0);

		// above the maximum acts as the maximum
		configure(127, 1'b1);
		send_word(gte_pkg::OP_WALK_ALL, WALK_DFS, 6'd0, 6'd0);

		repeat (8) begin
			case ($urandom_range(0, 6))
				0:       nv = 1;
				1:       nv = 2;
				2:       nv = $urandom_range(3, 16);
				3:       nv = MAX_VERTICES;
				4:       nv = 0;
				5:       nv = $urandom_range(MAX_VERTICES + 1, 127);
				default: nv = $urandom_range(17, MAX_VERTICES - 1);
			endcase
			configure(nv, 1'($urandom_range(0, 1)));
			repeat (7) send_random_word();
		end

		// eight vertices, undirected: vertex check and walks over the stored graph
		configure(8, 1'b0);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_DFS, 6'd1, 6'd2);
		send_word(gte_pkg::OP_ADD_EDGE, WALK_BFS, 6'd9, 6'd1);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ONE, WALK_BFS, 6'd7, 6'd0);
		send_word(gte_pkg::OP_WALK_ALL, WALK_DFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ALL, WALK_BFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd8, 6'd0);

		configure(MAX_VERTICES, 1'b1);
		send_word(gte_pkg::OP_WALK_ALL, WALK_BFS, 6'd0, 6'd0);
		send_word(gte_pkg::OP_WALK_ONE, WALK_DFS, 6'd63, 6'd0);

		configure(4, 1'($urandom_range(0, 1)));
		repeat (10) send_random_word();

		wait_drained();
		$display("Run covered %0d input words under %0d register settings, %0d results checked.",
			words_sent, settings_used, words_checked);
		$display("Full edge store reported %0d times, out-of-range vertex %0d times.",
			full_hits, bad_hits);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
hdl/gte_pkg.sv
hdl/graph_traversal_engine_top.sv
dv/gte_traversal_checker.sv
dv/testbench.sv
